[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the parser's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/txp_pkg.sv]
// ----------------------------------------------------------------------------
// Text-to-integer parser package
// Shared types, character codes, status codes and sizing constants.
// ----------------------------------------------------------------------------
package txp_pkg;

    // Default sizing of the parser.
    localparam int TXP_WORD_BITS   = 32;
    localparam int TXP_MAX_LEN     = 255;
    localparam int TXP_QUEUE_DEPTH = 2;

    // Port payload widths.
    localparam int TXP_IN_TDATA_W  = 8;
    localparam int TXP_OUT_TDATA_W = 48;

    // Configuration register indexes.
    localparam logic CFG_NUMBER_BASE   = 1'b0;
    localparam logic CFG_UNSIGNED_MODE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_BAD_BASE  = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Digit value of a character that is no digit in any base.
    localparam logic [5:0] DIGIT_NONE = 6'd36;
    localparam logic [5:0] BASE_MAX   = 6'd36;

    // Classified character as it travels from front to back.
    typedef struct packed {
        logic [5:0] digit;
        logic       is_space;
        logic       is_plus;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
    } t_char_class;

endpackage

[sv/txp_front.sv]
// ----------------------------------------------------------------------------
// Parser front end
// Accepts characters and classifies them for the parse engine.
// ----------------------------------------------------------------------------
module txp_front (
    input  logic                 i_s_tvalid,
    input  logic [7:0]           i_s_tdata,
    output logic                 o_s_tready,
    input  logic                 i_q_full,
    output logic                 o_push,
    output txp_pkg::t_char_class o_item
);
    import txp_pkg::*;

    logic [7:0] w_upper_off;
    logic [7:0] w_lower_off;
    logic [7:0] w_num_off;

    // Accept whenever the queue has a free slot.
    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    assign w_num_off   = i_s_tdata - CH_0;
    assign w_upper_off = i_s_tdata - CH_UA + 8'd10;
    assign w_lower_off = i_s_tdata - CH_LA + 8'd10;

    // Digit value: decimal digits, then letters of either case as 10..35.
    always_comb begin
        if (i_s_tdata >= CH_0 && i_s_tdata <= CH_9) begin
            o_item.digit = w_num_off[5:0];
        end else if (i_s_tdata >= CH_UA && i_s_tdata <= CH_UZ) begin
            o_item.digit = w_upper_off[5:0];
        end else if (i_s_tdata >= CH_LA && i_s_tdata <= CH_LZ) begin
            o_item.digit = w_lower_off[5:0];
        end else begin
            o_item.digit = DIGIT_NONE;
        end
    end

    // Character kinds the parse engine branches on.
    assign o_item.is_space = (i_s_tdata == CH_SPACE) ||
                             (i_s_tdata >= CH_TAB && i_s_tdata <= CH_CR);
    assign o_item.is_plus  = (i_s_tdata == CH_PLUS);
    assign o_item.is_minus = (i_s_tdata == CH_MINUS);
    assign o_item.is_zero  = (i_s_tdata == CH_0);
    assign o_item.is_x     = (i_s_tdata == CH_LX) || (i_s_tdata == CH_UX);

endmodule

[sv/txp_queue.sv]
// ----------------------------------------------------------------------------
// Parser item queue
// Short queue of classified characters between front end and parse engine.
// ----------------------------------------------------------------------------
module txp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  txp_pkg::t_char_class i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output txp_pkg::t_char_class o_item
);
    import txp_pkg::*;

    localparam int PTR_W = (TXP_QUEUE_DEPTH > 1) ? $clog2(TXP_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TXP_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TXP_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TXP_QUEUE_DEPTH);

    t_char_class            r_slots [TXP_QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   w_do_push;
    logic                   w_do_pop;

    assign o_full   = (r_count == CNT_FULL);
    assign o_valid  = (r_count != '0);
    assign o_item   = r_slots[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Fill level follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

endmodule

[sv/txp_back.sv]
// ----------------------------------------------------------------------------
// Parser back end
// Per-string parse engine: sign, base prefix, digit accumulation, result.
// ----------------------------------------------------------------------------
module txp_back #(
    parameter int WORD_BITS = txp_pkg::TXP_WORD_BITS,
    parameter int MAX_LEN   = txp_pkg::TXP_MAX_LEN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  txp_pkg::t_char_class i_q_item,
    output logic                 o_q_pop,
    input  logic [5:0]           i_number_base,
    input  logic                 i_unsigned_mode,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [31:0]          o_value,
    output logic [7:0]           o_end_offset,
    output logic [1:0]           o_status
);
    import txp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PROD_W = WORD_BITS + 7;
    localparam logic [CNT_W-1:0]     LEN_MAX = CNT_W'(MAX_LEN);
    localparam logic [WORD_BITS-1:0] HALF    = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Parse phases.
    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    logic [2:0]           r_phase,       n_phase;
    logic [WORD_BITS-1:0] r_acc,         n_acc;
    logic                 r_neg,         n_neg;
    logic                 r_ovf,         n_ovf;
    logic                 r_digit_seen,  n_digit_seen;
    logic [5:0]           r_active_base, n_active_base;
    logic [CNT_W-1:0]     r_count,       n_count;

    logic                 r_out_valid;
    logic [31:0]          r_out_value;
    logic [7:0]           r_out_offset;
    logic [1:0]           r_out_status;

    logic                 w_fire;
    logic                 w_take;
    logic                 w_bump;
    logic                 w_bad_base;
    logic                 w_finish;
    logic [5:0]           w_first_base;
    logic [5:0]           w_tk_base;
    logic [CNT_W-1:0]     w_fin_off;
    logic [PROD_W-1:0]    w_prod;
    logic                 w_fits;
    logic                 w_emit;
    logic [WORD_BITS-1:0] w_neg_mag;
    logic [WORD_BITS-1:0] w_fin_val;
    logic [1:0]           w_fin_status;
    logic [CNT_W-1:0]     w_res_off;
    logic [WORD_BITS+31:0] w_val_ext;
    logic [CNT_W+7:0]     w_off_ext;

    // One character is processed when the result register can take a result.
    assign w_fire  = i_q_valid && (!r_out_valid || i_m_tready);
    assign o_q_pop = w_fire;

    // Base used by the first significant character of a string.
    assign w_first_base = (r_phase == PH_SPACE && r_count == '0) ? i_number_base
                                                                  : r_active_base;

    // Phase decisions.
    always_comb begin
        n_phase       = r_phase;
        n_acc         = r_acc;
        n_neg         = r_neg;
        n_ovf         = r_ovf;
        n_digit_seen  = r_digit_seen;
        n_active_base = r_active_base;
        w_take        = 1'b0;
        w_bump        = 1'b0;
        w_bad_base    = 1'b0;
        w_finish      = 1'b0;
        w_tk_base     = r_active_base;
        w_fin_off     = r_count;
        unique case (r_phase)
            PH_SPACE, PH_SIGNED: begin
                if (r_phase == PH_SPACE && r_count == '0) begin
                    n_active_base = i_number_base;
                end
                if (r_phase == PH_SPACE && r_count == '0 &&
                    (i_number_base == 6'd1 || i_number_base > BASE_MAX)) begin
                    w_bad_base = 1'b1;
                end else if (r_phase == PH_SPACE && i_q_item.is_space) begin
                    w_bump = 1'b1;
                end else if (r_phase == PH_SPACE &&
                             (i_q_item.is_plus || i_q_item.is_minus)) begin
                    n_neg   = i_q_item.is_minus;
                    w_bump  = 1'b1;
                    n_phase = PH_SIGNED;
                end else if ((w_first_base == 6'd0 || w_first_base == 6'd16) &&
                             i_q_item.is_zero) begin
                    // A leading zero may open a prefix.
                    n_digit_seen = 1'b1;
                    n_acc        = '0;
                    w_bump       = 1'b1;
                    n_phase      = PH_ZERO;
                end else begin
                    n_active_base = (w_first_base == 6'd0) ? 6'd10 : w_first_base;
                    w_tk_base     = n_active_base;
                    n_phase       = PH_DIGITS;
                    w_take        = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_q_item.is_x) begin
                    if (r_active_base == 6'd0) begin
                        n_active_base = 6'd16;
                    end
                    w_bump  = 1'b1;
                    n_phase = PH_PREFIX;
                end else begin
                    n_active_base = (r_active_base == 6'd0) ? 6'd8 : r_active_base;
                    w_tk_base     = n_active_base;
                    n_phase       = PH_DIGITS;
                    w_take        = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (i_q_item.digit < 6'd16) begin
                    n_phase = PH_DIGITS;
                    w_take  = 1'b1;
                end else begin
                    // Bare prefix: the offset points at the x.
                    w_finish  = 1'b1;
                    w_fin_off = (r_count != '0) ? r_count - 1'b1 : '0;
                end
            end
            default: begin
                w_take = 1'b1;
            end
        endcase

        // Digit step: accept the digit or end the string.
        if (w_take) begin
            if (w_tk_base < 6'd2 || i_q_item.digit >= w_tk_base) begin
                w_finish  = 1'b1;
                w_fin_off = r_count;
            end else begin
                n_digit_seen = 1'b1;
                w_bump       = 1'b1;
                if (w_fits) begin
                    n_acc = w_prod[WORD_BITS-1:0];
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end

        n_count = r_count;
        if (w_bump && r_count < LEN_MAX) begin
            n_count = r_count + 1'b1;
        end
    end

    // Multiply-add of the accumulator; a product that needs upper bits overflows.
    assign w_prod = {7'b0, r_acc} * PROD_W'(w_tk_base) + PROD_W'(i_q_item.digit);
    assign w_fits = (w_prod[PROD_W-1:WORD_BITS] == '0);

    // Final value with saturation.
    assign w_neg_mag = '0 - r_acc;
    always_comb begin
        w_fin_val    = r_neg ? w_neg_mag : r_acc;
        w_fin_status = ST_OK;
        if (i_unsigned_mode) begin
            if (r_ovf) begin
                w_fin_val    = '1;
                w_fin_status = ST_RANGE;
            end
        end else if (r_ovf || (r_neg ? (r_acc > HALF) : r_acc[WORD_BITS-1])) begin
            w_fin_val    = r_neg ? HALF : ~HALF;
            w_fin_status = ST_RANGE;
        end
    end

    assign w_emit    = w_bad_base || w_finish;
    assign w_res_off = (w_bad_base || !r_digit_seen) ? '0 : w_fin_off;
    assign w_val_ext = {32'b0, ((w_bad_base || !r_digit_seen) ? '0 : w_fin_val)};
    assign w_off_ext = {8'b0, w_res_off};

    // String state; every result returns it to the start of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SPACE;
            r_acc         <= '0;
            r_neg         <= 1'b0;
            r_ovf         <= 1'b0;
            r_digit_seen  <= 1'b0;
            r_active_base <= '0;
            r_count       <= '0;
        end else if (w_fire) begin
            if (w_emit) begin
                r_phase       <= PH_SPACE;
                r_acc         <= '0;
                r_neg         <= 1'b0;
                r_ovf         <= 1'b0;
                r_digit_seen  <= 1'b0;
                r_active_base <= '0;
                r_count       <= '0;
            end else begin
                r_phase       <= n_phase;
                r_acc         <= n_acc;
                r_neg         <= n_neg;
                r_ovf         <= n_ovf;
                r_digit_seen  <= n_digit_seen;
                r_active_base <= n_active_base;
                r_count       <= n_count;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_value  <= w_val_ext[31:0];
            r_out_offset <= w_off_ext[7:0];
            if (w_bad_base) begin
                r_out_status <= ST_BAD_BASE;
            end else if (!r_digit_seen) begin
                r_out_status <= ST_NO_DIGITS;
            end else begin
                r_out_status <= w_fin_status;
            end
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_value      = r_out_value;
    assign o_end_offset = r_out_offset;
    assign o_status     = r_out_status;

endmodule

[sv/text_to_integer_parser.sv]
// ----------------------------------------------------------------------------
// Text-to-integer parser
// Streaming string-to-integer conversion with base detection and saturation.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per item and sustains one item per
// clock cycle unless the result stream stalls; the rate is set by the parse
// engine, which does one multiply-add of the accumulator by the base per
// cycle. Leading whitespace and an optional sign are skipped, base 0 picks 8,
// 10 or 16 from the prefix, and the first character that is not a digit of
// the base ends the string: that character is consumed and one result item
// (value, end offset, status) is registered. A character enters a two-entry
// queue when accepted, and the result register is loaded when the engine pops
// it. The user must make base and mode writes only between strings; the block
// does not enforce this. The base is sampled on the first character of each string.
module text_to_integer_parser #(
    parameter int WORD_BITS = txp_pkg::TXP_WORD_BITS,
    parameter int MAX_LEN   = txp_pkg::TXP_MAX_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Character stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [txp_pkg::TXP_IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] ch
    // Result stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [31:0] value, [39:32] end_offset, [41:40] status, [47:42] zero
    output logic [txp_pkg::TXP_OUT_TDATA_W-1:0] o_m_tdata,
    // Configuration writes.
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [5:0]                          i_cfg_data
);
    import txp_pkg::*;

    logic [5:0]  r_number_base;
    logic        r_unsigned_mode;

    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_q_valid;
    t_char_class w_in_item;
    t_char_class w_q_item;
    logic [31:0] w_value;
    logic [7:0]  w_end_offset;
    logic [1:0]  w_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base   <= 6'd10;
            r_unsigned_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUMBER_BASE:   r_number_base   <= i_cfg_data;
                CFG_UNSIGNED_MODE: r_unsigned_mode <= i_cfg_data[0];
                default:           r_number_base   <= r_number_base;
            endcase
        end
    end

    txp_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .o_s_tready (o_s_tready),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_item     (w_in_item)
    );

    txp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    txp_back #(
        .WORD_BITS (WORD_BITS),
        .MAX_LEN   (MAX_LEN)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_pop),
        .i_number_base   (r_number_base),
        .i_unsigned_mode (r_unsigned_mode),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_value         (w_value),
        .o_end_offset    (w_end_offset),
        .o_status        (w_status)
    );

    // Pack the result item.
    assign o_m_tdata = {6'b0, w_status, w_end_offset, w_value};

endmodule

[sv/txp_checker.sv]
// ----------------------------------------------------------------------------
// Parser port checker
// Watches the result stream of the parser and is bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module txp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [txp_pkg::TXP_OUT_TDATA_W-1:0] o_m_tdata
);
    import txp_pkg::*;

    logic [1:0] w_status;
    logic       w_empty_result;

    assign w_status       = o_m_tdata[41:40];
    assign w_empty_result = (o_m_tdata[39:0] == 40'd0);

    // A stalled result stays offered.
    `ASSERT_CLK(a_hold_valid, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `ASSERT_CLK(a_hold_data, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "result changed while stalled")

    // Failed parses carry a zero value and offset.
    `ASSERT_CLK(a_empty_fail, i_clk, i_rst_n, o_m_tvalid && (w_status == ST_BAD_BASE || w_status == ST_NO_DIGITS) |-> w_empty_result, "failed parse with nonzero payload")

    // No result right after reset.
    `ASSERT_CLK(a_reset_quiet, i_clk, i_rst_n, $rose(i_rst_n) |-> !o_m_tvalid, "result offered out of reset")

endmodule

bind text_to_integer_parser txp_checker u_txp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-to-integer parser testbench
// Streams characters into the parser and compares every parsed number, end
// offset and status against a cycle-free prediction of the parse. Directed
// strings cover the special cases, then random strings run under a series of
// base and mode settings with random idling on both streams and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import txp_pkg::*;

    // Parse phases of the prediction.
    typedef enum logic [2:0] {
        SCAN_BLANK,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_PREFIX,
        SCAN_DIGITS
    } scan_state_t;

    // One parse result as it leaves the block.
    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  end_offset;
        logic [1:0]  status;
    } parse_result_t;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_s_tvalid   = 1'b0;
    logic                       o_s_tready;
    logic [TXP_IN_TDATA_W-1:0]  i_s_tdata    = '0;   // [7:0] ch
    logic                       o_m_tvalid;
    logic                       i_m_tready   = 1'b0;
    // [31:0] value, [39:32] end_offset, [41:40] status
    logic [TXP_OUT_TDATA_W-1:0] o_m_tdata;
    logic                       i_cfg_we     = 1'b0;
    logic                       i_cfg_index  = 1'b0;
    logic [5:0]                 i_cfg_data   = '0;

    logic [7:0]    pending_chars[$];
    parse_result_t expected_results[$];
    int unsigned   chars_pushed = 0;
    int unsigned   results_seen = 0;
    int unsigned   error_count  = 0;
    int unsigned   cyc          = 0;
    logic          hold_off     = 1'b0;

    // Register copies and string state of the prediction.
    logic [5:0]    reg_base     = 6'd10;
    logic          reg_unsigned = 1'b0;
    scan_state_t   scan_state   = SCAN_BLANK;
    logic [31:0]   acc_word     = '0;
    logic          minus_flag   = 1'b0;
    logic          ovf_flag     = 1'b0;
    logic          have_digit   = 1'b0;
    logic [5:0]    run_base     = '0;
    logic [7:0]    char_tally   = '0;

    text_to_integer_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock and reset.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // ------------------------------------------------------------------------
    // Prediction of the parse
    // ------------------------------------------------------------------------
    function automatic int unsigned digit_of(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return c - CH_0;
        if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + 10;
        if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + 10;
        return DIGIT_NONE;
    endfunction

    function automatic void clear_string();
        scan_state = SCAN_BLANK;
        acc_word   = '0;
        minus_flag = 1'b0;
        ovf_flag   = 1'b0;
        have_digit = 1'b0;
        run_base   = '0;
        char_tally = '0;
    endfunction

    function automatic void bump_tally();
        if (char_tally < TXP_MAX_LEN) char_tally = char_tally + 1;
    endfunction

    // Ends the string: applies sign and range, then starts a new string.
    function automatic bit close_string(input logic [7:0] off, output parse_result_t res);
        logic [31:0] mag;
        bit          big;
        mag = acc_word;
        res.end_offset = off;
        res.status     = ST_OK;
        if (!have_digit) begin
            res.value      = '0;
            res.end_offset = '0;
            res.status     = ST_NO_DIGITS;
        end else if (reg_unsigned) begin
            if (ovf_flag) begin
                res.value  = '1;
                res.status = ST_RANGE;
            end else begin
                res.value = minus_flag ? -mag : mag;
            end
        end else begin
            big = ovf_flag || (minus_flag ? mag > 32'h8000_0000 : mag > 32'h7FFF_FFFF);
            if (big) begin
                res.value  = minus_flag ? 32'h8000_0000 : 32'h7FFF_FFFF;
                res.status = ST_RANGE;
            end else begin
                res.value = minus_flag ? -mag : mag;
            end
        end
        clear_string();
        return 1'b1;
    endfunction

    // Folds one digit into the accumulator, or ends the string on a non-digit.
    function automatic bit fold_digit(input logic [7:0] c, output parse_result_t res);
        int unsigned d;
        logic [31:0] lim;
        logic [31:0] rem;
        d = digit_of(c);
        if (run_base < 2 || d >= run_base) return close_string(char_tally, res);
        lim = 32'hFFFF_FFFF / run_base;
        rem = 32'hFFFF_FFFF % run_base;
        have_digit = 1'b1;
        if (acc_word < lim || (acc_word == lim && d <= rem))
            acc_word = acc_word * run_base + d;
        else
            ovf_flag = 1'b1;
        bump_tally();
        return 1'b0;
    endfunction

    // First character after blanks and sign: a leading zero may open a prefix.
    function automatic bit lead_char(input logic [7:0] c, output parse_result_t res);
        if ((run_base == 0 || run_base == 16) && c == CH_0) begin
            have_digit = 1'b1;
            acc_word   = '0;
            bump_tally();
            scan_state = SCAN_ZERO;
            return 1'b0;
        end
        if (run_base == 0) run_base = 10;
        scan_state = SCAN_DIGITS;
        return fold_digit(c, res);
    endfunction

    // Takes one character; returns 1 when it ends the string with a result.
    function automatic bit parse_char(input logic [7:0] c, output parse_result_t res);
        case (scan_state)
            SCAN_BLANK: begin
                if (char_tally == 0) begin
                    run_base = reg_base;
                    if (run_base == 1 || run_base > BASE_MAX) begin
                        res.value      = '0;
                        res.end_offset = '0;
                        res.status     = ST_BAD_BASE;
                        clear_string();
                        return 1'b1;
                    end
                end
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    bump_tally();
                    return 1'b0;
                end
                if (c == CH_MINUS || c == CH_PLUS) begin
                    minus_flag = (c == CH_MINUS);
                    bump_tally();
                    scan_state = SCAN_SIGN;
                    return 1'b0;
                end
                return lead_char(c, res);
            end
            SCAN_SIGN: begin
                return lead_char(c, res);
            end
            SCAN_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    if (run_base == 0) run_base = 16;
                    bump_tally();
                    scan_state = SCAN_PREFIX;
                    return 1'b0;
                end
                if (run_base == 0) run_base = 8;
                scan_state = SCAN_DIGITS;
                return fold_digit(c, res);
            end
            SCAN_PREFIX: begin
                if (digit_of(c) < 16) begin
                    scan_state = SCAN_DIGITS;
                    return fold_digit(c, res);
                end
                // A bare prefix parses as zero ending at the 'x'.
                return close_string(char_tally > 0 ? char_tally - 8'd1 : 8'd0, res);
            end
            default: begin
                return fold_digit(c, res);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver, monitor and checking
    // ------------------------------------------------------------------------
    // Random idling, with the start of each window of the cycle count left free of gaps.
    function automatic bit take_gap();
        return (cyc % 1500 >= 300) && ($urandom_range(0, 99) < 38);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result(input logic [TXP_OUT_TDATA_W-1:0] tdata);
        parse_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result item %h", tdata));
            return;
        end
        want = expected_results.pop_front();
        results_seen++;
        if (tdata[31:0] !== want.value)
            report_mismatch($sformatf("result %0d value %h, expected %h",
                                      results_seen, tdata[31:0], want.value));
        if (tdata[39:32] !== want.end_offset)
            report_mismatch($sformatf("result %0d end_offset %0d, expected %0d",
                                      results_seen, tdata[39:32], want.end_offset));
        if (tdata[41:40] !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_seen, tdata[41:40], want.status));
    endtask

    // Character driver: predicts on every accepted item, then offers the next.
    always @(posedge i_clk) begin : drive_chars
        parse_result_t res;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (parse_char(i_s_tdata, res)) expected_results.push_back(res);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_chars.size() != 0 && !take_gap()) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_chars.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) check_result(o_m_tdata);
            i_m_tready <= !hold_off && !take_gap();
        end
    end

    // One long receiver hold-off while characters keep coming, to fill the block.
    initial begin : receiver_holdoff
        do @(negedge i_clk); while (results_seen < 30 || pending_chars.size() <= 20);
        hold_off = 1'b1;
        repeat (150) @(posedge i_clk);
        @(negedge i_clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_char(input logic [7:0] c);
        pending_chars.push_back(c);
        chars_pushed++;
    endtask

    task automatic push_text(input string s);
        foreach (s[k]) push_char(s[k]);
    endtask

    task automatic push_digit(input int unsigned radix);
        int unsigned d;
        d = $urandom_range(0, radix - 1);
        if (d < 10) push_char(8'(CH_0 + d));
        else push_char(8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10));
    endtask

    task automatic push_number(input longint unsigned v, input int unsigned radix);
        logic [7:0]  digits[$];
        int unsigned d;
        do begin
            d = 32'(v % radix);
            digits.push_front(d < 10 ? 8'(CH_0 + d) : 8'(CH_UA + d - 10));
            v = v / radix;
        end while (v != 0);
        foreach (digits[k]) push_char(digits[k]);
    endtask

    // Writes a register while the block is idle and mirrors it in the prediction.
    task automatic write_reg(input logic idx, input logic [5:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NUMBER_BASE) reg_base = val;
        else reg_unsigned = val[0];
        @(negedge i_clk);
    endtask

    // Waits until every item is taken and every result is in, then lets a
    // character that ends no string settle through the pipeline.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_chars.size() != 0 || i_s_tvalid || expected_results.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // One random string for the current base, or a burst of noise.
    task automatic push_string();
        string           stops;
        int unsigned     pick;
        int unsigned     n;
        int unsigned     radix;
        longint unsigned v;
        stops = " ,;.\n";
        pick  = $urandom_range(0, 99);
        if (pick < 15) begin
            n = $urandom_range(1, 6);
            repeat (n) push_char(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            v = $urandom_range(0, 5);
            push_char(v == 5 ? CH_SPACE : 8'(CH_TAB + v));
        end
        case ($urandom_range(0, 2))
            0: push_char(CH_MINUS);
            1: push_char(CH_PLUS);
            default: ;
        endcase
        radix = reg_base;
        if (radix == 0 || radix == 16) begin
            case ($urandom_range(0, 3))
                0: begin
                    push_char(CH_0);
                    push_char($urandom_range(0, 1) ? CH_LX : CH_UX);
                    radix = 16;
                end
                1: begin
                    if (radix == 0) begin
                        push_char(CH_0);
                        radix = 8;
                    end
                end
                default: if (radix == 0) radix = 10;
            endcase
        end
        if (radix < 2 || radix > BASE_MAX) radix = 10;
        // Numbers right at the signed and unsigned limits.
        if (pick < 30) begin
            case ($urandom_range(0, 5))
                0: v = 64'h7FFF_FFFF;
                1: v = 64'h8000_0000;
                2: v = 64'h8000_0001;
                3: v = 64'hFFFF_FFFF;
                4: v = 64'h1_0000_0000;
                default: v = $urandom;
            endcase
            push_number(v, radix);
        end else begin
            n = $urandom_range(0, radix < 4 ? 34 : radix < 8 ? 22 : radix < 16 ? 12 : 9);
            repeat (n) push_digit(radix);
        end
        if ($urandom_range(0, 1)) push_char(stops[$urandom_range(0, stops.len() - 1)]);
        else push_char(8'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        logic [5:0]  base_plan[9];
        logic [5:0]  base;
        int unsigned k;
        int unsigned phase_no;
        int unsigned mark;
        int unsigned random_start;
        base_plan = '{6'd0, 6'd2, BASE_MAX, 6'd16, 6'd8, 6'd10, 6'd1, 6'd63, 6'd37};
        clear_string();
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // Directed: blanks, sign and signed saturation; character code extremes;
        // a string left open across a base change, which ends under the old base;
        // a bare hex prefix; invalid bases; a negated unsigned result.
        push_text("\t-2147483649 ");
        push_char(8'hFF);
        push_char(8'h00);
        push_text("12");
        wait_idle();
        write_reg(CFG_NUMBER_BASE, 6'd0);
        push_text("z0x;");
        wait_idle();
        write_reg(CFG_NUMBER_BASE, 6'd1);
        push_text("5");
        wait_idle();
        write_reg(CFG_NUMBER_BASE, 6'd63);
        push_text("a");
        wait_idle();
        write_reg(CFG_NUMBER_BASE, BASE_MAX);
        write_reg(CFG_UNSIGNED_MODE, 6'd1);
        push_text("-zz ");
        wait_idle();

        // Random strings under a series of settings, extremes first.
        random_start = chars_pushed;
        phase_no     = 0;
        while (chars_pushed - random_start < 400) begin
            if (phase_no < 9) begin
                base = base_plan[phase_no];
            end else begin
                k = $urandom_range(0, 9);
                base = k < 8 ? 6'($urandom_range(2, 36)) :
                       k == 8 ? 6'd0 : 6'($urandom_range(37, 63));
            end
            write_reg(CFG_NUMBER_BASE, base);
            write_reg(CFG_UNSIGNED_MODE,
                      phase_no < 9 ? 6'(phase_no % 2) : 6'($urandom_range(0, 1)));
            mark = chars_pushed;
            while (chars_pushed - mark < 40) push_string();
            wait_idle();
            phase_no++;
        end

        // A string longer than the offset counter: it must stop at its limit.
        write_reg(CFG_NUMBER_BASE, 6'd10);
        write_reg(CFG_UNSIGNED_MODE, 6'd0);
        repeat (260) push_char(CH_SPACE);
        push_text("7;");
        wait_idle();

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/txp_pkg.sv
sv/txp_front.sv
sv/txp_queue.sv
sv/txp_back.sv
sv/text_to_integer_parser.sv
sv/txp_checker.sv
dv/tb_top.sv
